// File: rtl/fir55_pkg.sv
// Shared constants, coefficient ROM and arithmetic widths for the 55-tap FIR filter.
// Depends on nothing; imported by the channel interfaces, the filter and its checker.
`default_nettype none

package fir55_pkg;

    // Filter geometry and sample format.
    localparam int TAPS         = 55;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_W       = 16;
    localparam int COEF_FRAC    = 15;
    localparam int ROM_LEN      = 55;

    // Derived widths.
    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W  = PROD_W + TAP_W;

    // Low-pass coefficients in Q1.15, newest sample first.
    localparam int COEF_ROM [ROM_LEN] = '{
        -39, -78, -67, -16, 83, 131, 81, -75, -214, -206,
        2, 279, 390, 171, -278, -616, -487, 142, 854, 1012,
        259, -1066, -1963, -1339, 1213, 4965, 8317, 9657, 8317, 4965,
        1213, -1339, -1963, -1066, 259, 1012, 854, 142, -487, -616,
        -278, 171, 390, 279, 2, -206, -214, -75, 81, 131,
        83, -16, -67, -78, -39
    };

    // Coefficient lookup; taps beyond the ROM have a zero coefficient.
    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_W-1:0] k);
        int idx;
        idx = int'(k);
        if (idx < ROM_LEN) begin
            return COEF_W'(COEF_ROM[idx]);
        end
        return '0;
    endfunction

endpackage

`default_nettype wire

// File: rtl/fir55_in_if.sv
// Input sample channel: valid/ready handshake carrying one signed sample per transaction.
// Depends on fir55_pkg for the sample width.
`default_nettype none

interface fir55_in_if import fir55_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// File: rtl/fir55_out_if.sv
// Output sample channel: valid/ready handshake carrying one filtered sample per transaction.
// Depends on fir55_pkg for the sample width.
`default_nettype none

interface fir55_out_if import fir55_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered_out;

    modport source (output valid, output filtered_out, input ready);
    modport sink   (input valid, input filtered_out, output ready);
endinterface

`default_nettype wire

// File: rtl/fir_filter_55_tap.sv
// Top level of the 55-tap direct-form FIR filter with a circular delay line in a RAM.
// Depends on fir55_pkg and the fir55_in_if / fir55_out_if channel interfaces.
// A new input is taken only once the previous result has been loaded into the output register.
// The single multiply-accumulate unit walks one tap per cycle over the one read port of
// the delay-line RAM, through read, multiply and accumulate stages.
// Reset clears the per-entry valid bits at once, so the delay line reads as zero.
`default_nettype none

module fir_filter_55_tap import fir55_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fir55_in_if.sink    in_ch,
    fir55_out_if.source out_ch
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    localparam logic [TAP_W-1:0] LAST_IDX = TAP_W'(TAPS - 1);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));
    localparam logic signed [ACC_W-1:0] OUT_MAX  =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] OUT_MIN  = ACC_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

    // Delay-line storage.
    logic signed [SAMPLE_WIDTH-1:0] mem [TAPS];

    // Control state.
    state_t            state_reg, state_next;
    logic [TAP_W-1:0]  wp_reg, wp_next;
    logic [TAP_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic [TAPS-1:0]   valid_reg, valid_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg, out_data_next;

    // Pipeline: read, multiply, accumulate.
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic              rd_go_reg;
    logic              rd_last_reg;
    logic [TAP_W-1:0]  rd_tap_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic              prod_go_reg;
    logic              prod_last_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic              acc_done_reg;

    logic              accept;
    logic              issue;
    logic              out_load;
    logic [TAP_W-1:0]  wp_inc;
    logic signed [SAMPLE_WIDTH-1:0] tap_sample;
    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-1:0] shifted;

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign accept              = in_ch.valid && in_ch.ready;
    assign issue               = (state_reg == S_RUN);
    assign out_load            = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);
    assign wp_inc              = (wp_reg == LAST_IDX) ? '0 : wp_reg + TAP_W'(1);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.filtered_out = out_data_reg;

    // Round to nearest, drop the fraction and saturate to the sample range.
    assign rounded = acc_reg + ACC_HALF;
    assign shifted = rounded >>> COEF_FRAC;

    // Sequencer: write the new sample, then walk the taps from newest to oldest.
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rd_addr_next   = rd_addr_reg;
        tap_next       = tap_reg;
        valid_next     = valid_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    wp_next            = wp_inc;
                    valid_next[wp_inc] = 1'b1;
                    rd_addr_next       = wp_inc;
                    tap_next           = '0;
                    state_next         = S_RUN;
                end
            end
            S_RUN:
            begin
                rd_addr_next = (rd_addr_reg == '0) ? LAST_IDX : rd_addr_reg - TAP_W'(1);
                tap_next     = tap_reg + TAP_W'(1);
                if (tap_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (acc_done_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Accumulator clears when a new transaction starts and sums each product.
        if (accept)
        begin
            acc_next = '0;
        end
        else if (prod_go_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end

        // Output register frees when taken and loads the finished sample.
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (shifted > OUT_MAX)
            begin
                out_data_next = OUT_MAX[SAMPLE_WIDTH-1:0];
            end
            else if (shifted < OUT_MIN)
            begin
                out_data_next = OUT_MIN[SAMPLE_WIDTH-1:0];
            end
            else
            begin
                out_data_next = shifted[SAMPLE_WIDTH-1:0];
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            rd_addr_reg   <= '0;
            tap_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_go_reg     <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_go_reg   <= 1'b0;
            prod_last_reg <= 1'b0;
            acc_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rd_addr_reg   <= rd_addr_next;
            tap_reg       <= tap_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            rd_go_reg     <= issue;
            rd_last_reg   <= issue && (tap_reg == LAST_IDX);
            prod_go_reg   <= rd_go_reg;
            prod_last_reg <= rd_go_reg && rd_last_reg;
            acc_done_reg  <= prod_go_reg && prod_last_reg;
        end
    end

    // Delay-line RAM: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wp_inc] <= in_ch.sample_in;
        end
        rd_data_reg <= mem[rd_addr_reg];
        rd_vld_reg  <= valid_reg[rd_addr_reg];
        rd_tap_reg  <= tap_reg;
    end

    // An entry never written since reset reads as zero.
    assign tap_sample = rd_vld_reg ? rd_data_reg : '0;

    // Multiply and accumulate datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg     <= tap_sample * tap_coef(rd_tap_reg);
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// File: rtl/fir55_checker.sv
// Port-level checker for the 55-tap FIR filter, bound to the top level.
// Depends on fir55_pkg for the sample width.
`default_nettype none

module fir55_checker import fir55_pkg::*; (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0] filtered_out
);

    logic in_xact;
    logic out_xact;

    assign in_xact  = in_valid && in_ready;
    assign out_xact = out_valid && out_ready;

    // A stalled output transaction keeps its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered_out))
        else $error("filtered_out changed while stalled");

    // A waiting input transaction keeps its sample until the filter takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(sample_in))
        else $error("sample_in changed while waiting");

    // The filter works on one sample at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xact |=> !in_ready)
        else $error("input accepted back to back");

    // A result needs the whole tap sweep, so it never appears right after an input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xact |=> !$rose(out_valid))
        else $error("result appeared one cycle after input");

    // Accepting an input does not disturb a pending result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xact && out_valid && !out_xact |=> out_valid)
        else $error("pending result dropped");

endmodule

bind fir_filter_55_tap fir55_checker u_fir55_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .sample_in    (in_ch.sample_in),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .filtered_out (out_ch.filtered_out)
);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the 55-tap FIR filter: a directed table, then random streams.
// Depends on fir55_pkg, fir55_in_if, fir55_out_if and fir_filter_55_tap from the rtl folder.
`timescale 1ns / 1ps

module tb_top;
    import fir55_pkg::*;

    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          REPORT_MAX   = 10;
    localparam int          IDLE_PCT     = 30;
    localparam int          QUIET_FIRST  = 300;
    localparam int          QUIET_LAST   = 500;
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // One row of the directed table; a typed-in output is used only where has_value is set.
    typedef struct packed {
        sample_t sample;
        bit      has_value;
        sample_t value;
    } dir_row_t;

    localparam int DIR_ROWS = 20;

    // Reset gives zero; a full-scale negative impulse then reads out the negated taps.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{16'sd0,      1'b1, 16'sd0},
        '{S_MIN,       1'b1, 16'sd39},
        '{16'sd0,      1'b1, 16'sd78},
        '{16'sd0,      1'b1, 16'sd67},
        '{16'sd0,      1'b1, 16'sd16},
        '{16'sd0,      1'b1, -16'sd83},
        '{16'sd0,      1'b1, -16'sd131},
        '{S_MAX,       1'b0, 16'sd0},
        '{S_MAX,       1'b0, 16'sd0},
        '{S_MIN,       1'b0, 16'sd0},
        '{S_MIN,       1'b0, 16'sd0},
        '{16'sd1,      1'b0, 16'sd0},
        '{-16'sd1,     1'b0, 16'sd0},
        '{16'sh5555,   1'b0, 16'sd0},
        '{-16'sd21846, 1'b0, 16'sd0},
        '{16'sd16384,  1'b0, 16'sd0},
        '{-16'sd16384, 1'b0, 16'sd0},
        '{16'sh7ffe,   1'b0, 16'sd0},
        '{-16'sd32767, 1'b0, 16'sd0},
        '{16'sd0,      1'b0, 16'sd0}
    };

    logic clk;
    logic rst_n;

    fir55_in_if  in_ch ();
    fir55_out_if out_ch ();

    fir_filter_55_tap i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow copy of the delay line and its write pointer.
    sample_t shadow_line [TAPS];
    int      shadow_pos;

    sample_t expected_out_q [$];
    sample_t want_out;
    bit      idle_on;
    int      cycle_count;
    int      sent_count;
    int      checked_count;
    int      burst_count;
    int      mismatch_count;
    int      unexpected_count;

    // Clock generation.
    always #5 clk = ~clk;

    // Advance the shadow delay line by one sample and return the filter output.
    function automatic sample_t filter_next(input sample_t s);
        longint acc;
        longint y;
        int     idx;
        int     k;
        shadow_pos = (shadow_pos + 1 >= TAPS) ? 0 : shadow_pos + 1;
        shadow_line[shadow_pos] = s;
        idx = shadow_pos;
        acc = 0;
        for (k = 0; k < TAPS; k++)
        begin
            acc += longint'((k < ROM_LEN) ? COEF_ROM[k] : 0) * longint'(shadow_line[idx]);
            idx = (idx == 0) ? TAPS - 1 : idx - 1;
        end
        // Round to nearest with ties upward, then saturate to the sample range.
        y = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        if (y > longint'(S_MAX))
        begin
            y = longint'(S_MAX);
        end
        if (y < longint'(S_MIN))
        begin
            y = longint'(S_MIN);
        end
        return y[SAMPLE_WIDTH-1:0];
    endfunction

    // Present one sample, wait for its transaction and record the expected output.
    task automatic send_sample(input sample_t s, input bit has_value, input sample_t value);
        sample_t predicted;
        // Gaps of random length so that valid rises at every phase of the block's work.
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        predicted = filter_next(s);
        expected_out_q.push_back(has_value ? value : predicted);
        sent_count++;
    endtask

    // Fill the taps with full-scale samples whose signs follow the taps, which saturates.
    task automatic send_saturating_run(input bit negate);
        int      n;
        sample_t s;
        for (n = 0; n < TAPS; n++)
        begin
            s = ((COEF_ROM[n] >= 0) != negate) ? S_MAX : S_MIN;
            send_sample(s, 1'b0, '0);
        end
        burst_count++;
    endtask

    // Pick one random sample from a mix of full range, small values and extremes.
    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            return sample_t'($urandom);
        end
        else if (pick < 80)
        begin
            return sample_t'($urandom_range(0, 255)) - sample_t'(128);
        end
        else if (pick < 90)
        begin
            return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
        end
        return sample_t'($urandom_range(0, 2)) - sample_t'(1);
    endfunction

    // Output side: check each transaction and, while idling is enabled, stall ready at random.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_out_q.size() == 0)
            begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= REPORT_MAX)
                begin
                    $display("[%0d] unexpected output transaction: %0d",
                             cycle_count, out_ch.filtered_out);
                end
            end
            else
            begin
                want_out = expected_out_q.pop_front();
                checked_count++;
                if (out_ch.filtered_out !== want_out)
                begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= REPORT_MAX)
                    begin
                        $display("[%0d] output %0d: expected %0d, got %0d",
                                 cycle_count, checked_count, want_out, out_ch.filtered_out);
                    end
                end
            end
        end
        out_ch.ready <= rst_n && !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d outputs outstanding",
                     cycle_count, expected_out_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Reset, directed table, random streams, drain and verdict.
    initial
    begin
        int row;
        int n;
        int pick;
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.sample_in  = '0;
        out_ch.ready     = 1'b0;
        idle_on          = 1'b1;
        cycle_count      = 0;
        sent_count       = 0;
        checked_count    = 0;
        burst_count      = 0;
        mismatch_count   = 0;
        unexpected_count = 0;
        shadow_pos       = 0;
        for (n = 0; n < TAPS; n++)
        begin
            shadow_line[n] = '0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        for (row = 0; row < DIR_ROWS; row++)
        begin
            send_sample(DIR_TABLE[row].sample, DIR_TABLE[row].has_value, DIR_TABLE[row].value);
        end

        // Random part, with a stretch in the middle where neither side idles.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            idle_on = !(n >= QUIET_FIRST && n < QUIET_LAST);
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                send_saturating_run(pick[0]);
                n += TAPS;
            end
            else
            begin
                send_sample(random_sample(), 1'b0, '0);
                n++;
            end
        end
        idle_on = 1'b1;
        in_ch.valid <= 1'b0;

        // Drain, then give the block time to show any stray output.
        while (expected_out_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples (%0d directed, %0d saturating runs); checked %0d outputs.",
                 sent_count, DIR_ROWS, burst_count, checked_count);
        $display("Mismatches: %0d, unexpected outputs: %0d, cycles: %0d.",
                 mismatch_count, unexpected_count, cycle_count);
        if (mismatch_count == 0 && unexpected_count == 0 && expected_out_q.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
